// ===== rtl/core/ksf_pkg.sv =====
// ----------------------------------------------------------------------------
// Kuan speckle filter package
// Shared constants and register codes for the speckle filter unit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ksf_pkg;

   // default geometry of the unit
   localparam int unsigned DEF_MAX_WIDTH  = 1024;
   localparam int unsigned DEF_MAX_WINDOW = 15;
   localparam int unsigned DEF_PIXEL_BITS = 16;

   // frame limits and register widths
   localparam int unsigned MAX_HEIGHT    = 1024;
   localparam int unsigned HEIGHT_BITS   = 11;
   localparam int unsigned CFG_ADDR_BITS = 2;
   localparam int unsigned CFG_DATA_BITS = 16;

   // reset values of the registers
   localparam int unsigned RESET_WIDTH  = 640;
   localparam int unsigned RESET_HEIGHT = 480;
   localparam int unsigned RESET_WINDOW = 7;
   localparam int unsigned RESET_LOOKS  = 256;

   // window used when window_size is zero
   localparam int unsigned DEFAULT_WINDOW = 7;

   // one look in Q8.8
   localparam int unsigned ONE_LOOK   = 256;
   localparam int unsigned LOOK_SHIFT = 8;

   typedef enum logic [CFG_ADDR_BITS-1:0] {
      REG_FRAME_WIDTH  = 2'd0,
      REG_FRAME_HEIGHT = 2'd1,
      REG_WINDOW_SIZE  = 2'd2,
      REG_EQUIV_LOOKS  = 2'd3
   } ksf_reg_type;

endpackage

// ===== rtl/core/ksf_line_mem.sv =====
// ----------------------------------------------------------------------------
// Line store
// Single-port-write, single-port-read pixel memory with registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksf_line_mem #(
   parameter int unsigned ADDR_BITS = 14,
   parameter int unsigned DATA_BITS = 16
) (
   input  logic                 clock,
   input  logic                 we,
   input  logic [ADDR_BITS-1:0] waddr,
   input  logic [DATA_BITS-1:0] wdata,
   input  logic                 re,
   input  logic [ADDR_BITS-1:0] raddr,
   output logic [DATA_BITS-1:0] rdata
);

   logic [DATA_BITS-1:0] mem_ff [2**ADDR_BITS];
   logic [DATA_BITS-1:0] rdata_ff;

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// ===== rtl/core/ksf_mul.sv =====
// ----------------------------------------------------------------------------
// Shift-add multiplier
// Wide operand times narrow operand, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksf_mul #(
   parameter int unsigned A_BITS = 92,
   parameter int unsigned B_BITS = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [A_BITS-1:0] a,
   input  logic [B_BITS-1:0] b,
   output logic              done,
   output logic [A_BITS-1:0] product
);

   logic              run_ff, run_in;
   logic [A_BITS-1:0] acc_ff, acc_in;
   logic [A_BITS-1:0] a_ff, a_in;
   logic [B_BITS-1:0] b_ff, b_in;

   // finished once the multiplier bits are used up
   assign done    = run_ff && (b_ff == '0);
   assign product = acc_ff;

   always_comb begin
      run_in = run_ff;
      acc_in = acc_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      if (start) begin
         run_in = 1'b1;
         acc_in = '0;
         a_in   = a;
         b_in   = b;
      end else if (done) begin
         run_in = 1'b0;
      end else if (run_ff) begin
         if (b_ff[0]) begin
            acc_in = acc_ff + a_ff;
         end
         a_in = a_ff << 1;
         b_in = b_ff >> 1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
   end

endmodule

// ===== rtl/core/ksf_div.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Produces a short quotient of a wide dividend, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ksf_div #(
   parameter int unsigned NUM_BITS = 92,
   parameter int unsigned QUO_BITS = 17
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [NUM_BITS-1:0] num,
   input  logic [NUM_BITS-1:0] den,
   output logic                done,
   output logic [QUO_BITS-1:0] quo
);

   localparam int unsigned SHW = NUM_BITS + QUO_BITS;
   localparam int unsigned CW  = $clog2(QUO_BITS + 1);

   logic                run_ff, run_in;
   logic [CW-1:0]       cnt_ff, cnt_in;
   logic [NUM_BITS-1:0] rem_ff, rem_in;
   logic [SHW-1:0]      dsh_ff, dsh_in;
   logic [QUO_BITS-1:0] quo_ff, quo_in;
   logic                ge;

   assign ge   = SHW'(rem_ff) >= dsh_ff;
   assign done = run_ff && (cnt_ff == '0);
   assign quo  = quo_ff;

   always_comb begin
      run_in = run_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      dsh_in = dsh_ff;
      quo_in = quo_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(QUO_BITS);
         rem_in = num;
         dsh_in = SHW'(den) << (QUO_BITS - 1);
         quo_in = '0;
      end else if (done) begin
         run_in = 1'b0;
      end else if (run_ff) begin
         // trial subtract of the aligned divisor
         if (ge) begin
            rem_in = rem_ff - dsh_ff[NUM_BITS-1:0];
         end
         quo_in = {quo_ff[QUO_BITS-2:0], ge};
         dsh_in = dsh_ff >> 1;
         cnt_in = cnt_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
      end else begin
         run_ff <= run_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      dsh_ff <= dsh_in;
      quo_ff <= quo_in;
   end

endmodule

// ===== rtl/core/kuan_speckle_filter_unit.sv =====
// ----------------------------------------------------------------------------
// Kuan speckle filter unit
// Adaptive speckle filter over a raster pixel stream, reflect-101 borders.
// An item that releases a result sweeps its window through the single
// line-store read port, then, unless the window sum is zero, runs through the
// shift-add multiplier and the divider. Items that release no result are
// accepted while the unit is idle and leave it idle.
// Reset loads the configuration reset values and clears frame positions; the
// line store is not cleared, the frame order never reads an unwritten entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kuan_speckle_filter_unit #(
   parameter int unsigned MAX_WIDTH  = ksf_pkg::DEF_MAX_WIDTH,
   parameter int unsigned MAX_WINDOW = ksf_pkg::DEF_MAX_WINDOW,
   parameter int unsigned PIXEL_BITS = ksf_pkg::DEF_PIXEL_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   // input stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [((PIXEL_BITS+7)/8)*8-1:0]    req_tdata,  // pixel_value
   input  logic                               req_tuser,  // cmd
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [((PIXEL_BITS+7)/8)*8-1:0]    rsp_tdata,  // filtered_value
   output logic                               rsp_tlast,  // frame_last
   // register writes
   input  logic                               csr_we,
   input  logic [ksf_pkg::CFG_ADDR_BITS-1:0]  csr_addr,
   input  logic [ksf_pkg::CFG_DATA_BITS-1:0]  csr_wdata
);

   localparam int unsigned PB   = PIXEL_BITS;
   localparam int unsigned DBW  = ((PB + 7) / 8) * 8;
   localparam int unsigned XW   = $clog2(MAX_WIDTH);
   localparam int unsigned WW   = $clog2(MAX_WIDTH + 1);
   localparam int unsigned HW   = ksf_pkg::HEIGHT_BITS;
   localparam int unsigned YW   = $clog2(ksf_pkg::MAX_HEIGHT);
   localparam int unsigned LW   = (WW > HW) ? WW : HW;
   localparam int unsigned TW   = WW + HW;
   localparam int unsigned KW   = $clog2(MAX_WINDOW + 1);
   localparam int unsigned SLW  = $clog2(MAX_WINDOW + 1);
   localparam int unsigned NW   = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
   localparam int unsigned KLIM = (MAX_WINDOW % 2 == 0) ? MAX_WINDOW - 1 : MAX_WINDOW;
   localparam int unsigned SW   = PB + NW;
   localparam int unsigned QW   = 2 * PB + NW;
   localparam int unsigned AW   = 3 * PB + 3 * NW + 20;
   localparam int unsigned BW   = (SW > 16) ? SW : 16;
   localparam int unsigned QB   = PB + 1;
   localparam int unsigned MAW  = SLW + XW;

   typedef enum logic [15:0] {
      ST_IDLE  = 16'b0000_0000_0000_0001,
      ST_CTR   = 16'b0000_0000_0000_0010,
      ST_PRE   = 16'b0000_0000_0000_0100,
      ST_RD    = 16'b0000_0000_0000_1000,
      ST_DRAIN = 16'b0000_0000_0001_0000,
      ST_CHK   = 16'b0000_0000_0010_0000,
      ST_MQN   = 16'b0000_0000_0100_0000,
      ST_MSS   = 16'b0000_0000_1000_0000,
      ST_MED   = 16'b0000_0001_0000_0000,
      ST_MT1   = 16'b0000_0010_0000_0000,
      ST_MNC   = 16'b0000_0100_0000_0000,
      ST_MT2   = 16'b0000_1000_0000_0000,
      ST_MDN   = 16'b0001_0000_0000_0000,
      ST_DIV   = 16'b0010_0000_0000_0000,
      ST_OUT   = 16'b0100_0000_0000_0000
   } ksf_state_type;

   // one reflect-101 step of a mirrored index; dir high means the index
   // and the position move the same way
   function automatic logic [LW:0] walk(input logic [LW-1:0] pos, input logic dir,
                                        input logic [LW-1:0] n, input logic fwd);
      logic [LW-1:0] np;
      logic          nd;
      np = pos;
      nd = dir;
      if (n > LW'(1)) begin
         if (fwd == dir) begin
            if (pos == n - LW'(1)) begin
               np = n - LW'(2);
               nd = ~dir;
            end else begin
               np = pos + LW'(1);
            end
         end else begin
            if (pos == '0) begin
               np = LW'(1);
               nd = ~dir;
            end else begin
               np = pos - LW'(1);
            end
         end
      end
      return {nd, np};
   endfunction

   // configuration
   logic [10:0]  fw_ff, fw_in;
   logic [10:0]  fh_ff, fh_in;
   logic [3:0]   ws_ff, ws_in;
   logic [15:0]  el_ff, el_in;
   logic         geo_wr;

   // derived geometry
   logic [WW-1:0]  w_eff;
   logic [HW-1:0]  h_eff;
   logic [5:0]     k_raw;
   logic [KW-1:0]  k_eff;
   logic [KW-1:0]  p_eff;
   logic [NW-1:0]  n_eff;
   logic [TW-1:0]  total;
   logic [TW+1:0]  need_raw;
   logic [TW-1:0]  need;
   logic [15:0]    e_eff;

   // frame positions
   logic [TW-1:0] in_pos_ff, in_pos_in;
   logic [TW-1:0] out_pos_ff, out_pos_in;
   logic [XW-1:0] in_x_ff, in_x_in, out_x_ff, out_x_in;
   logic [YW-1:0] in_y_ff, in_y_in, out_y_ff, out_y_in;
   logic          acc_req, pix_ok, due, last;
   logic [TW-1:0] in_pos_nx;

   // window sweep
   ksf_state_type st_ff, st_in;
   logic [LW-1:0] row_pos_ff, row_pos_in, col_pos_ff, col_pos_in, col0_pos_ff, col0_pos_in;
   logic          row_dir_ff, row_dir_in, col_dir_ff, col_dir_in, col0_dir_ff, col0_dir_in;
   logic [KW-1:0] pc_ff, pc_in, rc_ff, rc_in, cc_ff, cc_in;
   logic [XW-1:0] cx_ff, cx_in;
   logic [YW-1:0] cy_ff, cy_in;
   logic          lst_ff, lst_in;
   logic [LW:0]   row_step, col_step, row_back, col_back;

   // accumulation pipeline
   logic          rv1_ff, rv1_in, rv2_ff, rv2_in, cv_ff, cv_in;
   logic [PB-1:0] v_ff, v_in, c_ff, c_in;
   logic [2*PB-1:0] sq_ff, sq_in;
   logic [SW-1:0] s_ff, s_in;
   logic [QW-1:0] q_ff, q_in;

   // ratio datapath
   logic [AW-1:0] nq_ff, nq_in, ss_ff, ss_in, d_ff, d_in;
   logic [AW-1:0] anum_ff, anum_in, aden_ff, aden_in, num_ff, num_in;
   logic          neg_ff, neg_in;
   logic [PB-1:0] res_ff, res_in;
   logic [AW-1:0] s2x, d_c, aden_c;
   logic [SW-1:0] dif_c;

   // output register
   logic          out_vld_ff, out_vld_in;
   logic [PB-1:0] out_data_ff, out_data_in;
   logic          out_last_ff, out_last_in;

   // shared units
   logic          mul_start, mul_done;
   logic [AW-1:0] mul_a, mul_p;
   logic [BW-1:0] mul_b;
   logic          div_start, div_done;
   logic [AW-1:0] div_num, div_den;
   logic [QB-1:0] div_quo;

   // line store
   logic           mem_we, mem_re;
   logic [MAW-1:0] mem_waddr, mem_raddr;
   logic [PB-1:0]  mem_q;

   // ------------------------------------------------------------------
   // effective geometry
   always_comb begin
      if (fw_ff == '0) begin
         w_eff = WW'(1);
      end else if (32'(fw_ff) > MAX_WIDTH) begin
         w_eff = WW'(MAX_WIDTH);
      end else begin
         w_eff = WW'(fw_ff);
      end
      if (fh_ff == '0) begin
         h_eff = HW'(1);
      end else if (32'(fh_ff) > ksf_pkg::MAX_HEIGHT) begin
         h_eff = HW'(ksf_pkg::MAX_HEIGHT);
      end else begin
         h_eff = fh_ff;
      end
      k_raw = (ws_ff == '0) ? 6'(ksf_pkg::DEFAULT_WINDOW) : 6'(ws_ff);
      if (!k_raw[0]) begin
         k_raw = k_raw + 6'd1;
      end
      if (32'(k_raw) > KLIM) begin
         k_raw = 6'(KLIM);
      end
      k_eff = KW'(k_raw);
      p_eff = k_eff >> 1;
      n_eff = NW'(k_eff) * NW'(k_eff);
      e_eff = (el_ff == '0) ? 16'(ksf_pkg::ONE_LOOK) : el_ff;
   end

   assign total    = TW'(w_eff) * TW'(h_eff);
   assign need_raw = (TW+2)'(out_pos_ff) + (TW+2)'(p_eff) * (TW+2)'(w_eff) + (TW+2)'(p_eff)
                     + (TW+2)'(1);
   assign need     = (need_raw > (TW+2)'(total)) ? total : need_raw[TW-1:0];

   // ------------------------------------------------------------------
   // accept and frame positions
   assign req_tready = (st_ff == ST_IDLE);
   assign acc_req    = req_tvalid && req_tready;
   assign pix_ok     = acc_req && !req_tuser && (in_pos_ff < total);
   assign in_pos_nx  = in_pos_ff + TW'(pix_ok);
   assign due        = acc_req && (in_pos_nx >= need) && (out_pos_ff < total);
   assign last       = (out_pos_ff + TW'(1)) >= total;

   assign mem_we    = pix_ok;
   assign mem_waddr = {in_y_ff[SLW-1:0], in_x_ff};

   assign geo_wr = csr_we && (csr_addr != ksf_pkg::REG_EQUIV_LOOKS);

   always_comb begin
      fw_in = fw_ff;
      fh_in = fh_ff;
      ws_in = ws_ff;
      el_in = el_ff;
      if (csr_we) begin
         case (csr_addr)
            ksf_pkg::REG_FRAME_WIDTH:  fw_in = csr_wdata[10:0];
            ksf_pkg::REG_FRAME_HEIGHT: fh_in = csr_wdata[10:0];
            ksf_pkg::REG_WINDOW_SIZE:  ws_in = csr_wdata[3:0];
            ksf_pkg::REG_EQUIV_LOOKS:  el_in = csr_wdata;
            default:                   el_in = el_ff;
         endcase
      end

      in_pos_in  = in_pos_ff;
      out_pos_in = out_pos_ff;
      in_x_in    = in_x_ff;
      in_y_in    = in_y_ff;
      out_x_in   = out_x_ff;
      out_y_in   = out_y_ff;
      if (pix_ok) begin
         in_pos_in = in_pos_nx;
         if (WW'(in_x_ff) + WW'(1) == w_eff) begin
            in_x_in = '0;
            in_y_in = in_y_ff + YW'(1);
         end else begin
            in_x_in = in_x_ff + XW'(1);
         end
      end
      if (due) begin
         out_pos_in = out_pos_ff + TW'(1);
         if (WW'(out_x_ff) + WW'(1) == w_eff) begin
            out_x_in = '0;
            out_y_in = out_y_ff + YW'(1);
         end else begin
            out_x_in = out_x_ff + XW'(1);
         end
      end
      // frame done or geometry changed: restart
      if ((due && last) || geo_wr) begin
         in_pos_in  = '0;
         out_pos_in = '0;
         in_x_in    = '0;
         in_y_in    = '0;
         out_x_in   = '0;
         out_y_in   = '0;
      end
   end

   // ------------------------------------------------------------------
   // sweep and ratio sequencer
   assign row_step = walk(row_pos_ff, row_dir_ff, LW'(h_eff), 1'b1);
   assign col_step = walk(col_pos_ff, col_dir_ff, LW'(w_eff), 1'b1);
   assign row_back = walk(row_pos_ff, row_dir_ff, LW'(h_eff), 1'b0);
   assign col_back = walk(col_pos_ff, col_dir_ff, LW'(w_eff), 1'b0);

   assign s2x    = AW'(ss_ff) << ksf_pkg::LOOK_SHIFT;
   assign d_c    = nq_ff - mul_p;
   assign aden_c = mul_p + (d_ff << ksf_pkg::LOOK_SHIFT);
   assign dif_c  = (SW'(mul_p) >= s_ff) ? SW'(mul_p) - s_ff : s_ff - SW'(mul_p);

   always_comb begin
      st_in       = st_ff;
      row_pos_in  = row_pos_ff;
      row_dir_in  = row_dir_ff;
      col_pos_in  = col_pos_ff;
      col_dir_in  = col_dir_ff;
      col0_pos_in = col0_pos_ff;
      col0_dir_in = col0_dir_ff;
      pc_in       = pc_ff;
      rc_in       = rc_ff;
      cc_in       = cc_ff;
      cx_in       = cx_ff;
      cy_in       = cy_ff;
      lst_in      = lst_ff;
      nq_in       = nq_ff;
      ss_in       = ss_ff;
      d_in        = d_ff;
      anum_in     = anum_ff;
      aden_in     = aden_ff;
      num_in      = num_ff;
      neg_in      = neg_ff;
      res_in      = res_ff;
      mul_start   = 1'b0;
      mul_a       = '0;
      mul_b       = '0;
      div_start   = 1'b0;
      div_num     = '0;
      div_den     = '0;
      mem_re      = 1'b0;
      mem_raddr   = '0;
      out_vld_in  = out_vld_ff;
      out_data_in = out_data_ff;
      out_last_in = out_last_ff;

      // read pipeline: store data, square, accumulate
      rv1_in = 1'b0;
      rv2_in = rv1_ff;
      cv_in  = 1'b0;
      v_in   = mem_q;
      sq_in  = (2*PB)'(mem_q) * (2*PB)'(mem_q);
      c_in   = cv_ff ? mem_q : c_ff;
      s_in   = rv2_ff ? s_ff + SW'(v_ff) : s_ff;
      q_in   = rv2_ff ? q_ff + QW'(sq_ff) : q_ff;

      if (rsp_tvalid && rsp_tready) begin
         out_vld_in = 1'b0;
      end

      case (st_ff)
         ST_IDLE: begin
            if (due) begin
               st_in      = ST_CTR;
               row_pos_in = LW'(out_y_ff);
               row_dir_in = 1'b1;
               col_pos_in = LW'(out_x_ff);
               col_dir_in = 1'b1;
               pc_in      = '0;
               rc_in      = '0;
               cc_in      = '0;
               cx_in      = out_x_ff;
               cy_in      = out_y_ff;
               lst_in     = last;
               s_in       = '0;
               q_in       = '0;
            end
         end
         ST_CTR: begin
            mem_re    = 1'b1;
            mem_raddr = {cy_ff[SLW-1:0], cx_ff};
            cv_in     = 1'b1;
            st_in     = ST_PRE;
         end
         ST_PRE: begin
            // walk back half a window to the top left corner
            if (pc_ff == p_eff) begin
               col0_pos_in = col_pos_ff;
               col0_dir_in = col_dir_ff;
               st_in       = ST_RD;
            end else begin
               {row_dir_in, row_pos_in} = row_back;
               {col_dir_in, col_pos_in} = col_back;
               pc_in = pc_ff + KW'(1);
            end
         end
         ST_RD: begin
            mem_re    = 1'b1;
            mem_raddr = {row_pos_ff[SLW-1:0], col_pos_ff[XW-1:0]};
            rv1_in    = 1'b1;
            if (cc_ff == k_eff - KW'(1)) begin
               cc_in      = '0;
               col_pos_in = col0_pos_ff;
               col_dir_in = col0_dir_ff;
               if (rc_ff == k_eff - KW'(1)) begin
                  st_in = ST_DRAIN;
               end else begin
                  rc_in = rc_ff + KW'(1);
                  {row_dir_in, row_pos_in} = row_step;
               end
            end else begin
               cc_in = cc_ff + KW'(1);
               {col_dir_in, col_pos_in} = col_step;
            end
         end
         ST_DRAIN: begin
            if (!rv1_ff && !rv2_ff) begin
               st_in = ST_CHK;
            end
         end
         ST_CHK: begin
            if (s_ff == '0) begin
               res_in = c_ff;
               st_in  = ST_OUT;
            end else begin
               mul_start = 1'b1;
               mul_a     = AW'(q_ff);
               mul_b     = BW'(n_eff);
               st_in     = ST_MQN;
            end
         end
         ST_MQN: begin
            if (mul_done) begin
               nq_in     = mul_p;
               mul_start = 1'b1;
               mul_a     = AW'(s_ff);
               mul_b     = BW'(s_ff);
               st_in     = ST_MSS;
            end
         end
         ST_MSS: begin
            // D = N*Q - S*S, then e*D
            if (mul_done) begin
               ss_in     = mul_p;
               d_in      = d_c;
               mul_start = 1'b1;
               mul_a     = d_c;
               mul_b     = BW'(e_eff);
               st_in     = ST_MED;
            end
         end
         ST_MED: begin
            if (mul_done) begin
               if (s2x >= mul_p) begin
                  // no adaptive weight: rounded window mean
                  div_start = 1'b1;
                  div_num   = AW'({s_ff, 1'b0}) + AW'(n_eff);
                  div_den   = AW'({n_eff, 1'b0});
                  st_in     = ST_DIV;
               end else begin
                  anum_in   = mul_p - s2x;
                  aden_in   = aden_c;
                  mul_start = 1'b1;
                  mul_a     = aden_c;
                  mul_b     = BW'(s_ff);
                  st_in     = ST_MT1;
               end
            end
         end
         ST_MT1: begin
            if (mul_done) begin
               num_in    = mul_p;
               mul_start = 1'b1;
               mul_a     = AW'(c_ff);
               mul_b     = BW'(n_eff);
               st_in     = ST_MNC;
            end
         end
         ST_MNC: begin
            // signed distance of N*c from S
            if (mul_done) begin
               neg_in    = SW'(mul_p) < s_ff;
               mul_start = 1'b1;
               mul_a     = anum_ff;
               mul_b     = BW'(dif_c);
               st_in     = ST_MT2;
            end
         end
         ST_MT2: begin
            if (mul_done) begin
               num_in    = neg_ff ? num_ff - mul_p : num_ff + mul_p;
               mul_start = 1'b1;
               mul_a     = aden_ff;
               mul_b     = BW'(n_eff);
               st_in     = ST_MDN;
            end
         end
         ST_MDN: begin
            // round half up: (2*num + den) / (2*den)
            if (mul_done) begin
               div_start = 1'b1;
               div_num   = (num_ff << 1) + mul_p;
               div_den   = mul_p << 1;
               st_in     = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_in = div_quo[PB-1:0];
               st_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!out_vld_ff || rsp_tready) begin
               out_vld_in  = 1'b1;
               out_data_in = res_ff;
               out_last_in = lst_ff;
               st_in       = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   // ------------------------------------------------------------------
   // registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fw_ff      <= 11'(ksf_pkg::RESET_WIDTH);
         fh_ff      <= 11'(ksf_pkg::RESET_HEIGHT);
         ws_ff      <= 4'(ksf_pkg::RESET_WINDOW);
         el_ff      <= 16'(ksf_pkg::RESET_LOOKS);
         in_pos_ff  <= '0;
         out_pos_ff <= '0;
         in_x_ff    <= '0;
         in_y_ff    <= '0;
         out_x_ff   <= '0;
         out_y_ff   <= '0;
         st_ff      <= ST_IDLE;
         rv1_ff     <= 1'b0;
         rv2_ff     <= 1'b0;
         cv_ff      <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         fw_ff      <= fw_in;
         fh_ff      <= fh_in;
         ws_ff      <= ws_in;
         el_ff      <= el_in;
         in_pos_ff  <= in_pos_in;
         out_pos_ff <= out_pos_in;
         in_x_ff    <= in_x_in;
         in_y_ff    <= in_y_in;
         out_x_ff   <= out_x_in;
         out_y_ff   <= out_y_in;
         st_ff      <= st_in;
         rv1_ff     <= rv1_in;
         rv2_ff     <= rv2_in;
         cv_ff      <= cv_in;
         out_vld_ff <= out_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      row_pos_ff  <= row_pos_in;
      row_dir_ff  <= row_dir_in;
      col_pos_ff  <= col_pos_in;
      col_dir_ff  <= col_dir_in;
      col0_pos_ff <= col0_pos_in;
      col0_dir_ff <= col0_dir_in;
      pc_ff       <= pc_in;
      rc_ff       <= rc_in;
      cc_ff       <= cc_in;
      cx_ff       <= cx_in;
      cy_ff       <= cy_in;
      lst_ff      <= lst_in;
      v_ff        <= v_in;
      sq_ff       <= sq_in;
      c_ff        <= c_in;
      s_ff        <= s_in;
      q_ff        <= q_in;
      nq_ff       <= nq_in;
      ss_ff       <= ss_in;
      d_ff        <= d_in;
      anum_ff     <= anum_in;
      aden_ff     <= aden_in;
      num_ff      <= num_in;
      neg_ff      <= neg_in;
      res_ff      <= res_in;
      out_data_ff <= out_data_in;
      out_last_ff <= out_last_in;
   end

   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = DBW'(out_data_ff);
   assign rsp_tlast  = out_last_ff;

   // ------------------------------------------------------------------
   // units
   ksf_line_mem #(
      .ADDR_BITS (MAW),
      .DATA_BITS (PB)
   ) u_mem (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (req_tdata[PB-1:0]),
      .re    (mem_re),
      .raddr (mem_raddr),
      .rdata (mem_q)
   );

   ksf_mul #(
      .A_BITS (AW),
      .B_BITS (BW)
   ) u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   ksf_div #(
      .NUM_BITS (AW),
      .QUO_BITS (QB)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_num),
      .den   (div_den),
      .done  (div_done),
      .quo   (div_quo)
   );

   // ------------------------------------------------------------------
   // checks
   ap_wr_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (st_ff == ST_IDLE))
      else $error("line store written during a window sweep");

   ap_pos_order: assert property (@(posedge clock) disable iff (reset)
      out_pos_ff <= in_pos_ff)
      else $error("output position ran ahead of input position");

   ap_out_load: assert property (@(posedge clock) disable iff (reset)
      (st_ff == ST_OUT && st_in == ST_IDLE) |=> rsp_tvalid)
      else $error("finished result not presented");

endmodule
